// ----- rtl/tbss_pkg.sv -----
// Shared types and constants for the triple buffer snapshot store.
// Used by tbss_clr, tbss_ctrl and the top module (not by tbss_ram); depends on nothing.
`timescale 1ns / 1ps

package tbss_pkg;

  localparam int SLOTS       = 256;
  localparam int SLOT_BITS   = 64;
  localparam int READER_BITS = 16;
  localparam int SLOT_AW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CAP_W       = 9;
  localparam int FUNC_W      = 3;
  localparam int IDX_W       = 8;
  localparam int EPOCH_W     = 64;
  localparam int DATA_W      = 64;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUBLISH    = 3'd0,
    FN_READ_BEGIN = 3'd1,
    FN_READ_END   = 3'd2,
    FN_READ_SLOT  = 3'd3,
    FN_WRITE_SLOT = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    COPY_0 = 2'd0,
    COPY_1 = 2'd1,
    COPY_2 = 2'd2
  } copy_t;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } clr_state_t;

  // Memory request issued on the accept edge of a request.
  typedef struct packed {
    logic                 we;
    copy_t                wcopy;
    logic                 re;
    logic [SLOT_AW-1:0]   addr;
    logic [SLOT_BITS-1:0] wdata;
  } mem_req_t;

  // Which copy feeds read_data in the result cycle.
  typedef struct packed {
    logic  valid;
    copy_t copy;
  } rsel_t;

endpackage

// ----- rtl/tbss_ram.sv -----
// Generic single-write, single-read memory with registered read data.
// Standalone; no package dependencies.
`timescale 1ns / 1ps

module tbss_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 64,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/tbss_clr.sv -----
// Post-reset clearing sequencer: sweeps every slot address once.
// Depends on tbss_pkg.
`timescale 1ns / 1ps

module tbss_clr
  import tbss_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  output logic               clearing,
  output logic [SLOT_AW-1:0] clr_addr
);

  clr_state_t         state, state_next;
  logic [SLOT_AW-1:0] addr_next;

  always_comb begin
    state_next = state;
    addr_next  = clr_addr;
    unique case (state)
      ST_CLEAR: begin
        addr_next = clr_addr + SLOT_AW'(1);
        if (clr_addr == SLOT_AW'(SLOTS - 1)) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        addr_next = clr_addr;
      end
      default: begin
        state_next = ST_CLEAR;
        addr_next  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state    <= state_next;
      clr_addr <= addr_next;
    end
  end

  assign clearing = (state != ST_RUN);

endmodule

// ----- rtl/tbss_ctrl.sv -----
// Request decode, copy/epoch/reader bookkeeping and result registers.
// Depends on tbss_pkg.
`timescale 1ns / 1ps

module tbss_ctrl
  import tbss_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [FUNC_W-1:0]    func,
  input  logic [IDX_W-1:0]     slot_addr,
  input  logic [DATA_W-1:0]    slot_data,
  input  logic                 cfg_we,
  input  logic [CAP_W-1:0]     cfg_wdata,
  output mem_req_t             mreq,
  output rsel_t                rsel,
  output logic                 done,
  output logic                 ok,
  output logic [EPOCH_W-1:0]   epoch_value
);

  localparam logic [READER_BITS-1:0] READER_MAX = '1;

  copy_t                  wc, rc, wc_next, rc_next, wc_inc;
  logic [EPOCH_W-1:0]     epoch, epoch_next, epoch_inc;
  logic [READER_BITS-1:0] readers, readers_next;
  logic [CAP_W-1:0]       cap;
  logic                   idx_ok;
  logic                   ok_next;
  logic [EPOCH_W-1:0]     epoch_out_next;
  logic                   rd_hit;

  always_comb begin
    unique case (wc)
      COPY_0:  wc_inc = COPY_1;
      COPY_1:  wc_inc = COPY_2;
      default: wc_inc = COPY_0;
    endcase
  end

  assign epoch_inc = epoch + EPOCH_W'(1);
  assign idx_ok    = ({1'b0, slot_addr} < cap) && ({24'd0, slot_addr} < 32'(SLOTS));

  always_comb begin
    wc_next        = wc;
    rc_next        = rc;
    epoch_next     = epoch;
    readers_next   = readers;
    ok_next        = 1'b0;
    epoch_out_next = '0;
    rd_hit         = 1'b0;
    mreq.we        = 1'b0;
    mreq.wcopy     = wc;
    mreq.re        = 1'b0;
    mreq.addr      = SLOT_AW'(slot_addr);
    mreq.wdata     = slot_data[SLOT_BITS-1:0];
    unique case (func_t'(func))
      FN_PUBLISH: begin
        // refuse while any reader holds the read copy
        if (readers == '0) begin
          wc_next        = wc_inc;
          rc_next        = wc;
          epoch_next     = epoch_inc;
          epoch_out_next = epoch_inc;
          ok_next        = 1'b1;
        end
      end
      FN_READ_BEGIN: begin
        if (readers != READER_MAX) begin
          readers_next = readers + READER_BITS'(1);
        end
        epoch_out_next = epoch;
        ok_next        = 1'b1;
      end
      FN_READ_END: begin
        if (readers != '0) begin
          readers_next = readers - READER_BITS'(1);
        end
        ok_next = 1'b1;
      end
      FN_READ_SLOT: begin
        rd_hit  = idx_ok;
        mreq.re = idx_ok & accept;
        ok_next = idx_ok;
      end
      FN_WRITE_SLOT: begin
        mreq.we = idx_ok & accept;
        ok_next = idx_ok;
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wc      <= COPY_0;
      rc      <= COPY_0;
      epoch   <= '0;
      readers <= '0;
      done    <= 1'b0;
      rsel    <= '0;
    end else begin
      done       <= accept;
      rsel.valid <= accept & rd_hit;
      if (accept) begin
        wc        <= wc_next;
        rc        <= rc_next;
        epoch     <= epoch_next;
        readers   <= readers_next;
        rsel.copy <= rc;
      end
    end
  end

  // capacity register is writable at any time, including during the clear sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CAP_RESET;
    end else if (cfg_we) begin
      cap <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ok          <= ok_next;
      epoch_value <= epoch_out_next;
    end
  end

endmodule

// ----- rtl/triple_buffer_snapshot_store.sv -----
// Triple buffer snapshot store: done strobes the cycle after start is taken.
// Throughput one request per cycle while busy is low; every request yields one result, which cannot be stalled.
// Each slot write lands in the write copy on the accept edge; reads return the read copy.
// After reset a clearing sweep zeroes all three copies, one slot address per cycle, and busy
// stays high until it has passed the last slot address; capacity writes are taken throughout.
// Depends on tbss_pkg, tbss_ram, tbss_clr and tbss_ctrl.
`timescale 1ns / 1ps

module triple_buffer_snapshot_store
  import tbss_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [FUNC_W-1:0]    func,
  input  logic [IDX_W-1:0]     slot_addr,
  input  logic [DATA_W-1:0]    slot_data,
  input  logic                 cfg_we,
  input  logic [CAP_W-1:0]     cfg_wdata,
  output logic                 done,
  output logic                 ok,
  output logic [EPOCH_W-1:0]   epoch_value,
  output logic [DATA_W-1:0]    read_data
);

  logic                 accept;
  logic                 clearing;
  logic [SLOT_AW-1:0]   clr_addr;
  mem_req_t             mreq;
  rsel_t                rsel;
  logic [2:0]           ram_we;
  logic [SLOT_AW-1:0]   ram_waddr;
  logic [SLOT_BITS-1:0] ram_wdata;
  logic [SLOT_BITS-1:0] ram_q [3];
  logic [SLOT_BITS-1:0] sel_q;

  assign busy   = clearing;
  assign accept = start & ~clearing;

  tbss_clr u_clr (
    .clk      (clk),
    .rst      (rst),
    .clearing (clearing),
    .clr_addr (clr_addr)
  );

  tbss_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .func        (func),
    .slot_addr   (slot_addr),
    .slot_data   (slot_data),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .mreq        (mreq),
    .rsel        (rsel),
    .done        (done),
    .ok          (ok),
    .epoch_value (epoch_value)
  );

  // clear all three copies together, otherwise write only the current write copy
  always_comb begin
    if (clearing) begin
      ram_we    = 3'b111;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = 3'b000;
      ram_waddr = mreq.addr;
      ram_wdata = mreq.wdata;
      unique case (mreq.wcopy)
        COPY_0:  ram_we = {2'b00, mreq.we};
        COPY_1:  ram_we = {1'b0, mreq.we, 1'b0};
        COPY_2:  ram_we = {mreq.we, 2'b00};
        default: ram_we = 3'b000;
      endcase
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_copy
    tbss_ram #(
      .DEPTH (SLOTS),
      .WIDTH (SLOT_BITS),
      .AW    (SLOT_AW)
    ) u_ram (
      .clk   (clk),
      .we    (ram_we[g]),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (mreq.re),
      .raddr (mreq.addr),
      .rdata (ram_q[g])
    );
  end

  always_comb begin
    unique case (rsel.copy)
      COPY_0:  sel_q = ram_q[0];
      COPY_1:  sel_q = ram_q[1];
      COPY_2:  sel_q = ram_q[2];
      default: sel_q = '0;
    endcase
  end

  assign read_data = rsel.valid ? DATA_W'(sel_q) : '0;

endmodule
